// ===== rtl/afp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package afp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] ANGLE_TAG = 8'h53;

    // 11-byte frame: two header bytes, then payload bytes 0..8
    localparam int FRAME_LEN    = 11;
    localparam int PAYLOAD_LEN  = FRAME_LEN - 2;
    localparam logic [3:0] PAYLOAD_LAST = 4'(PAYLOAD_LEN - 1);
    localparam int ANGLE_BYTES  = 6;

    localparam int ANGLE_W  = 16;
    localparam int PROD_W   = 22;
    localparam int RAW_W    = 17;
    localparam int CORR_W   = 18;
    localparam int OFFSET_W = 17;

    // raw * 180 * 256 / 32768 = raw * 45 / 32
    localparam logic signed [6:0] SCALE_MUL = 7'sd45;
    localparam int SCALE_SHIFT = 5;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_OFFSET   = 2'd2;

    localparam logic signed [OFFSET_W-1:0] ROLL_OFFSET_RESET  = 17'sd0;
    localparam logic signed [OFFSET_W-1:0] PITCH_OFFSET_RESET = 17'sd0;
    localparam logic signed [OFFSET_W-1:0] YAW_OFFSET_RESET   = 17'sd16896;

    localparam int FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        HUNT_IDLE,
        HUNT_SYNC,
        HUNT_COLLECT
    } hunt_state_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
    } frame_t;

endpackage

`default_nettype wire

// ===== rtl/afp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module afp_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_rx_byte,
    output logic                 push,
    output afp_pkg::frame_t      push_frame,
    input  wire logic            fifo_full
);
    import afp_pkg::*;

    hunt_state_t state_reg, state_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  bytes_reg [ANGLE_BYTES];
    logic        accept;
    logic        last_byte;
    logic        store_byte;

    always_comb begin
        last_byte  = (state_reg == HUNT_COLLECT) && (idx_reg == PAYLOAD_LAST);
        s_ready    = !(last_byte && fifo_full);
        accept     = s_valid && s_ready;
        push       = accept && last_byte;
        store_byte = accept && (state_reg == HUNT_COLLECT) && (idx_reg < 4'(ANGLE_BYTES));
        push_frame.roll  = {bytes_reg[1], bytes_reg[0]};
        push_frame.pitch = {bytes_reg[3], bytes_reg[2]};
        push_frame.yaw   = {bytes_reg[5], bytes_reg[4]};
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        if (accept) begin
            unique case (state_reg)
                HUNT_SYNC: begin
                    if (s_rx_byte == ANGLE_TAG) begin
                        state_next = HUNT_COLLECT;
                        idx_next   = '0;
                    end else if (s_rx_byte != SYNC_BYTE) begin
                        state_next = HUNT_IDLE;
                    end
                end
                HUNT_COLLECT: begin
                    if (idx_reg == PAYLOAD_LAST) begin
                        state_next = HUNT_IDLE;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                default: begin
                    state_next = (s_rx_byte == SYNC_BYTE) ? HUNT_SYNC : HUNT_IDLE;
                    idx_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HUNT_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_byte) begin
            bytes_reg[idx_reg[2:0]] <= s_rx_byte;
        end
    end

    a_push_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (state_reg == HUNT_COLLECT) && (idx_reg == PAYLOAD_LAST) && !fifo_full)
        else $error("frame pushed off the last payload byte or into a full queue");

    a_push_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (state_reg == HUNT_IDLE) && (idx_reg == '0))
        else $error("hunt not rearmed after a frame");

endmodule

`default_nettype wire

// ===== rtl/afp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module afp_fifo #(
    parameter int Depth = afp_pkg::FIFO_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire afp_pkg::frame_t push_frame,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output afp_pkg::frame_t      pop_frame
);
    import afp_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    frame_t          mem [Depth];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    always_comb begin
        full      = (count_reg == CW'(Depth));
        not_empty = (count_reg != '0);
        pop_frame = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == CW'($past(count_reg) + CW'(1)))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

// ===== rtl/afp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module afp_back (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [afp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [afp_pkg::OFFSET_W-1:0]           cfg_wdata,
    input  wire logic                                   fifo_not_empty,
    input  wire afp_pkg::frame_t                        fifo_frame,
    output logic                                        pop,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [afp_pkg::RAW_W-1:0]            m_raw_roll,
    output logic signed [afp_pkg::RAW_W-1:0]            m_raw_pitch,
    output logic signed [afp_pkg::RAW_W-1:0]            m_raw_yaw,
    output logic signed [afp_pkg::CORR_W-1:0]           m_corrected_roll,
    output logic signed [afp_pkg::CORR_W-1:0]           m_corrected_pitch,
    output logic signed [afp_pkg::CORR_W-1:0]           m_corrected_yaw
);
    import afp_pkg::*;

    logic signed [OFFSET_W-1:0] roll_off_reg, pitch_off_reg, yaw_off_reg;

    logic                       p1_valid_reg, p1_valid_next;
    logic signed [PROD_W-1:0]   prod_reg  [3];
    logic signed [PROD_W-1:0]   prod_next [3];
    logic signed [ANGLE_W-1:0]  angle [3];

    logic                       out_valid_reg, out_valid_next;
    logic signed [RAW_W-1:0]    raw_reg  [3];
    logic signed [RAW_W-1:0]    raw_next [3];
    logic signed [CORR_W-1:0]   corr_reg  [3];
    logic signed [CORR_W-1:0]   corr_next [3];
    logic signed [OFFSET_W-1:0] offset [3];
    logic                       out_free;
    logic                       load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_off_reg  <= ROLL_OFFSET_RESET;
            pitch_off_reg <= PITCH_OFFSET_RESET;
            yaw_off_reg   <= YAW_OFFSET_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROLL_OFFSET:  roll_off_reg  <= cfg_wdata;
                CFG_PITCH_OFFSET: pitch_off_reg <= cfg_wdata;
                CFG_YAW_OFFSET:   yaw_off_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        out_free = !out_valid_reg || m_ready;
        load_out = p1_valid_reg && out_free;
        pop      = fifo_not_empty && (!p1_valid_reg || out_free);

        angle[0]  = fifo_frame.roll;
        angle[1]  = fifo_frame.pitch;
        angle[2]  = fifo_frame.yaw;
        offset[0] = roll_off_reg;
        offset[1] = pitch_off_reg;
        offset[2] = yaw_off_reg;

        for (int i = 0; i < 3; i++) begin
            prod_next[i] = angle[i] * SCALE_MUL;
            // arithmetic shift: floor of the scaled value
            raw_next[i]  = prod_reg[i][PROD_W-1:SCALE_SHIFT];
            corr_next[i] = {raw_next[i][RAW_W-1], raw_next[i]}
                         - {offset[i][OFFSET_W-1], offset[i]};
        end

        if (pop) begin
            p1_valid_next = 1'b1;
        end else if (out_free) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
        out_valid_next = out_free ? p1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            prod_reg <= prod_next;
        end
        if (load_out) begin
            raw_reg  <= raw_next;
            corr_reg <= corr_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_raw_roll        = raw_reg[0];
    assign m_raw_pitch       = raw_reg[1];
    assign m_raw_yaw         = raw_reg[2];
    assign m_corrected_roll  = corr_reg[0];
    assign m_corrected_pitch = corr_reg[1];
    assign m_corrected_yaw   = corr_reg[2];

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !out_free) |=> p1_valid_reg)
        else $error("multiply stage dropped an item");

endmodule

`default_nettype wire

// ===== rtl/imu_angle_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_rx_byte (8b)
// m_       out        m_valid / m_ready   m_raw_{roll,pitch,yaw} (17b s),
//                                         m_corrected_{roll,pitch,yaw} (18b s)
// cfg_     in         cfg_wr_en           cfg_index (2b), cfg_wdata (17b)
//
// One byte per cycle while s_ready is high. m_valid rises once a frame's last
// byte has passed the queue write, multiply stage and output register, in order.
// Synchronous active-low reset; offsets reset to 0, 0 and 66 degrees.
// s_ready drops only on a frame's last byte while the frame queue is full.
// The back end stalls on m_ready alone; the queue decouples the two sides.

module imu_angle_frame_parser #(
    parameter int FifoDepth = afp_pkg::FIFO_DEPTH
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [afp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [afp_pkg::OFFSET_W-1:0]           cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [7:0]                             s_rx_byte,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [afp_pkg::RAW_W-1:0]            m_raw_roll,
    output logic signed [afp_pkg::RAW_W-1:0]            m_raw_pitch,
    output logic signed [afp_pkg::RAW_W-1:0]            m_raw_yaw,
    output logic signed [afp_pkg::CORR_W-1:0]           m_corrected_roll,
    output logic signed [afp_pkg::CORR_W-1:0]           m_corrected_pitch,
    output logic signed [afp_pkg::CORR_W-1:0]           m_corrected_yaw
);
    import afp_pkg::*;

    logic   push;
    frame_t push_frame;
    logic   fifo_full;
    logic   pop;
    logic   fifo_not_empty;
    frame_t pop_frame;

    afp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .push       (push),
        .push_frame (push_frame),
        .fifo_full  (fifo_full)
    );

    afp_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .full       (fifo_full),
        .pop        (pop),
        .not_empty  (fifo_not_empty),
        .pop_frame  (pop_frame)
    );

    afp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .fifo_not_empty    (fifo_not_empty),
        .fifo_frame        (pop_frame),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_raw_roll        (m_raw_roll),
        .m_raw_pitch       (m_raw_pitch),
        .m_raw_yaw         (m_raw_yaw),
        .m_corrected_roll  (m_corrected_roll),
        .m_corrected_pitch (m_corrected_pitch),
        .m_corrected_yaw   (m_corrected_yaw)
    );

endmodule

`default_nettype wire
